### hw/rtl/ssfp_pkg.sv
package ssfp_pkg;

  localparam int MAX_PHASES_DEF = 6;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int INC_REGS       = 6;

  // configuration register indexes
  localparam logic [2:0] REG_COUNT    = 3'd0;
  localparam logic [2:0] REG_INC_LAST = 3'd6;

  // CORDIC datapath, Q2.30 with headroom
  localparam int CW           = 34;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  // divider widths: numerator magnitude, denominator, quotient
  localparam int MW = 67;
  localparam int DW = 32;
  localparam int QW = 33;

  typedef struct packed {
    logic               valid;
    logic [2:0]         idx;
    logic               last;
    logic               bad;
    logic               neg_re;
    logic               neg_im;
    logic signed [31:0] g;
    logic [15:0]        a;
    logic [15:0]        b;
  } side_t;

endpackage

### hw/rtl/ssfp_cordic.sv
module ssfp_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [31:0]                   th_in,
  input  logic [31:0]                   psi_in,
  input  ssfp_pkg::side_t               side_in,
  output logic signed [ssfp_pkg::CW-1:0] cos_th,
  output logic signed [ssfp_pkg::CW-1:0] sin_th,
  output logic signed [ssfp_pkg::CW-1:0] cos_psi,
  output logic signed [ssfp_pkg::CW-1:0] sin_psi,
  output ssfp_pkg::side_t               side_out
);
  import ssfp_pkg::*;

  logic [31:0]           ang  [2];
  logic signed [CW-1:0]  x    [2][CORDIC_STEPS+1];
  logic signed [CW-1:0]  y    [2][CORDIC_STEPS+1];
  logic signed [CW-1:0]  z    [2][CORDIC_STEPS+1];
  logic                  flip [2][CORDIC_STEPS+1];
  logic signed [CW-1:0]  xo   [2];
  logic signed [CW-1:0]  yo   [2];
  side_t                 sd   [CORDIC_STEPS+1];

  assign ang[0] = th_in;
  assign ang[1] = psi_in;

  // side band follows the lanes stage by stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (en) begin
      sd[0] <= side_in;
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[s+1].valid <= 1'b0;
      end else if (en) begin
        sd[s+1] <= sd[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= sd[CORDIC_STEPS];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0] ang_rot;
    logic [31:0] ang_fold;
    logic        fold;

    // fold the angle into the right half plane, negate at the end
    always_comb begin
      ang_rot  = ang[l] + 32'h4000_0000;
      fold     = ang_rot[31];
      ang_fold = fold ? ang[l] + 32'h8000_0000 : ang[l];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[l][0]    <= CORDIC_GAIN;
        y[l][0]    <= '0;
        z[l][0]    <= {{(CW-32){ang_fold[31]}}, ang_fold};
        flip[l][0] <= fold;
      end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      logic signed [CW-1:0] atn;
      assign atn = CW'(ATAN_TURN[s]);
      always_ff @(posedge clk) begin
        if (en) begin
          if (!z[l][s][CW-1]) begin
            x[l][s+1] <= x[l][s] - (y[l][s] >>> s);
            y[l][s+1] <= y[l][s] + (x[l][s] >>> s);
            z[l][s+1] <= z[l][s] - atn;
          end else begin
            x[l][s+1] <= x[l][s] + (y[l][s] >>> s);
            y[l][s+1] <= y[l][s] - (x[l][s] >>> s);
            z[l][s+1] <= z[l][s] + atn;
          end
          flip[l][s+1] <= flip[l][s];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xo[l] <= flip[l][CORDIC_STEPS] ? -x[l][CORDIC_STEPS] : x[l][CORDIC_STEPS];
        yo[l] <= flip[l][CORDIC_STEPS] ? -y[l][CORDIC_STEPS] : y[l][CORDIC_STEPS];
      end
    end
  end

  assign cos_th  = xo[0];
  assign sin_th  = yo[0];
  assign cos_psi = xo[1];
  assign sin_psi = yo[1];

endmodule

### hw/rtl/ssfp_div.sv
module ssfp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [ssfp_pkg::MW-1:0]     mag_re,
  input  logic [ssfp_pkg::MW-1:0]     mag_im,
  input  logic [ssfp_pkg::DW-1:0]     den,
  input  ssfp_pkg::side_t             side_in,
  output logic [ssfp_pkg::QW-1:0]     q_re,
  output logic [ssfp_pkg::QW-1:0]     q_im,
  output logic                        ovf_re,
  output logic                        ovf_im,
  output ssfp_pkg::side_t             side_out
);
  import ssfp_pkg::*;

  localparam int HW = MW - QW;

  logic [MW-1:0] mag  [2];
  logic [DW-1:0] dv   [QW+1];
  logic [DW-1:0] rem  [2][QW+1];
  logic [QW-1:0] lo   [2][QW+1];
  logic [QW-1:0] quo  [2][QW+1];
  logic          ov   [2][QW+1];
  side_t         sd   [QW+1];

  assign mag[0] = mag_re;
  assign mag[1] = mag_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (en) begin
      sd[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= den;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[s+1].valid <= 1'b0;
      end else if (en) begin
        sd[s+1] <= sd[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[s+1] <= dv[s];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [HW-1:0] hi;
    assign hi = mag[l][MW-1:QW];

    // quotient needs more than QW bits: flag and saturate later
    always_ff @(posedge clk) begin
      if (en) begin
        ov[l][0]  <= hi >= HW'(den);
        rem[l][0] <= hi[DW-1:0];
        lo[l][0]  <= mag[l][QW-1:0];
        quo[l][0] <= '0;
      end
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      always_comb begin
        trial = {rem[l][s], lo[l][s][QW-1]};
        ge    = trial >= {1'b0, dv[s]};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][s+1] <= ge ? DW'(trial - {1'b0, dv[s]}) : trial[DW-1:0];
          lo[l][s+1]  <= {lo[l][s][QW-2:0], 1'b0};
          quo[l][s+1] <= {quo[l][s][QW-2:0], ge};
          ov[l][s+1]  <= ov[l][s];
        end
      end
    end
  end

  assign q_re     = quo[0][QW];
  assign q_im     = quo[1][QW];
  assign ovf_re   = ov[0][QW];
  assign ovf_im   = ov[1][QW];
  assign side_out = sd[QW];

endmodule

### hw/rtl/ssfp_ellipse_signal.sv
// Throughput: one sample per cycle while the output does not stall; each parameter set yields
//   phase_count samples, capped at MAX_PHASES and at six (none when the count is zero); a new
//   set is taken when idle or as the last sample of the current set issues, through the single
//   issue port into the pipeline.
// Reset: rst is synchronous, active high; it empties the pipeline and restores the
//   register file (count 4, increments 0, pi/2, pi, -pi/2, 0, 0).
module ssfp_ellipse_signal #(
  parameter int MAX_PHASES = ssfp_pkg::MAX_PHASES_DEF,
  parameter int ANGLE_BITS = ssfp_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // parameter set input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           gain,
  input  logic [15:0]                  coef_a,
  input  logic [15:0]                  coef_b,
  input  logic signed [ANGLE_BITS-1:0] off_res_angle,
  input  logic signed [ANGLE_BITS-1:0] rf_phase,
  // sample output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   sample_index,
  output logic signed [31:0]           real_part,
  output logic signed [31:0]           imag_part,
  output logic                         out_of_range,
  output logic                         last,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [ANGLE_BITS-1:0]        cfg_data
);
  import ssfp_pkg::*;

  localparam int SHIFT = 32 - ANGLE_BITS;
  localparam int LIM   = (MAX_PHASES < INC_REGS) ? MAX_PHASES : INC_REGS;

  // Whole pipeline moves as one: it holds only while a finished sample waits at the
  // output and the far side stalls. Bubbles travel with cleared valid bits.
  logic en;
  assign en = !(out_valid && out_stall);

  // ---------------------------------------------------------------------------
  // Register file. Writes are to be made only while idle; the block itself does not enforce this and is always ready.
  // ---------------------------------------------------------------------------
  logic [2:0]            phase_count;
  logic [ANGLE_BITS-1:0] phase_inc [INC_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count  <= 3'd4;
      phase_inc[0] <= '0;
      phase_inc[1] <= ANGLE_BITS'(1) << (ANGLE_BITS - 2);
      phase_inc[2] <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
      phase_inc[3] <= ANGLE_BITS'(3) << (ANGLE_BITS - 2);
      phase_inc[4] <= '0;
      phase_inc[5] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // index seven names nothing: drop the write
      if (cfg_index == REG_COUNT) begin
        phase_count <= cfg_data[2:0];
      end else if (cfg_index <= REG_INC_LAST) begin
        phase_inc[cfg_index - 3'd1] <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Issue stage: hold one parameter set and send one sample per cycle unless the pipeline stalls.
  // ---------------------------------------------------------------------------
  logic                busy;
  logic [2:0]          k;
  logic [2:0]          cnt;
  logic signed [31:0]  it_g;
  logic [15:0]         it_a;
  logic [15:0]         it_b;
  logic [31:0]         it_aa;
  logic [31:0]         it_t0;
  logic [31:0]         it_psi;
  logic [2:0]          cnt_next;
  logic                k_last;
  logic                in_xfer;
  logic [31:0]         t0_turn;
  logic [31:0]         p0_turn;
  logic [31:0]         half_turn;

  assign cnt_next  = (phase_count > 3'(LIM)) ? 3'(LIM) : phase_count;
  assign k_last    = (k == cnt - 3'd1);
  assign in_stall  = !en || (busy && !k_last);
  assign in_xfer   = in_valid && !in_stall;

  // theta0/2 rounds down at the angle resolution
  assign t0_turn   = {off_res_angle, {SHIFT{1'b0}}};
  assign p0_turn   = {rf_phase, {SHIFT{1'b0}}};
  assign half_turn = {off_res_angle[ANGLE_BITS-1], off_res_angle[ANGLE_BITS-1:1],
                      {SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
      cnt  <= '0;
    end else if (in_xfer) begin
      busy <= (cnt_next != 3'd0);
      k    <= '0;
      cnt  <= cnt_next;
    end else if (en && busy) begin
      if (k_last) begin
        busy <= 1'b0;
      end else begin
        k <= k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      it_g   <= gain;
      it_a   <= coef_a;
      it_b   <= coef_b;
      it_aa  <= 32'(coef_a * coef_a);
      it_t0  <= t0_turn;
      it_psi <= half_turn + p0_turn;
    end
  end

  // exact range test on b: b*(2^32 + a^2) > 2a*2^32
  logic [48:0] b_lhs;
  logic [48:0] b_rhs;
  assign b_lhs = 49'(it_b * {1'b1, it_aa});
  assign b_rhs = {it_a, 33'b0};

  side_t       is_side;
  logic [31:0] is_th;
  logic [31:0] is_psi;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_side.valid <= 1'b0;
    end else if (en) begin
      is_side.valid  <= busy;
      is_side.idx    <= k;
      is_side.last   <= k_last;
      is_side.bad    <= b_lhs > b_rhs;
      is_side.neg_re <= 1'b0;
      is_side.neg_im <= 1'b0;
      is_side.g      <= it_g;
      is_side.a      <= it_a;
      is_side.b      <= it_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_th  <= it_t0 - {phase_inc[k], {SHIFT{1'b0}}};
      is_psi <= it_psi;
    end
  end

  // ---------------------------------------------------------------------------
  // Sine and cosine of theta and psi, two lanes side by side.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] ct, st, cp, sp;
  side_t                cs_side;

  ssfp_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .th_in    (is_th),
    .psi_in   (is_psi),
    .side_in  (is_side),
    .cos_th   (ct),
    .sin_th   (st),
    .cos_psi  (cp),
    .sin_psi  (sp),
    .side_out (cs_side)
  );

  // ---------------------------------------------------------------------------
  // Numerator and denominator, at most one multiply level per stage.
  // ---------------------------------------------------------------------------
  side_t                  m1_side, m2_side, m3_side, m4_side, m5_side, m6_side;
  side_t                  m6_next;
  logic signed [2*CW-1:0] p_cc, p_ss, p_cs, p_sc;
  logic signed [CW+16:0]  bct;
  logic signed [CW-1:0]   m1_cp, m1_sp, m2_cp, m2_sp, m3_cp, m3_sp;
  logic signed [CW-1:0]   rc, rs;
  logic [DW-1:0]          m2_den, m3_den, m4_den, m5_den, m6_den;
  logic signed [CW+16:0]  arc, ars;
  logic signed [CW:0]     nr, ni;
  logic signed [MW-1:0]   pr, pim;
  logic [MW-1:0]          mag_re, mag_im;

  logic signed [2*CW:0]   dr_c, dr_s;
  logic signed [CW+17:0]  den_raw;

  always_comb begin
    dr_c    = (2*CW+1)'(p_cc) - (2*CW+1)'(p_ss);
    dr_s    = (2*CW+1)'(p_cs) + (2*CW+1)'(p_sc);
    den_raw = (CW+18)'(64'sd1073741824) - (CW+18)'(bct >>> 16);
  end

  // the product signs join the side band ahead of the divider
  always_comb begin
    m6_next        = m5_side;
    m6_next.neg_re = pr[MW-1];
    m6_next.neg_im = pim[MW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_side.valid <= 1'b0;
      m2_side.valid <= 1'b0;
      m3_side.valid <= 1'b0;
      m4_side.valid <= 1'b0;
      m5_side.valid <= 1'b0;
      m6_side.valid <= 1'b0;
    end else if (en) begin
      m1_side <= cs_side;
      m2_side <= m1_side;
      m3_side <= m2_side;
      m4_side <= m3_side;
      m5_side <= m4_side;
      m6_side <= m6_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products of the rotation and b*cos theta
      p_cc  <= ct * cp;
      p_ss  <= st * sp;
      p_cs  <= ct * sp;
      p_sc  <= st * cp;
      bct   <= $signed({1'b0, cs_side.b}) * ct;
      m1_cp <= cp;
      m1_sp <= sp;

      // back to Q2.30; clamp the denominator at one LSB
      rc     <= CW'(dr_c >>> 30);
      rs     <= CW'(dr_s >>> 30);
      m2_den <= (den_raw < (CW+18)'(1)) ? DW'(1) : DW'(den_raw);
      m2_cp  <= m1_cp;
      m2_sp  <= m1_sp;

      arc    <= $signed({1'b0, m2_side.a}) * rc;
      ars    <= $signed({1'b0, m2_side.a}) * rs;
      m3_den <= m2_den;
      m3_cp  <= m2_cp;
      m3_sp  <= m2_sp;

      nr     <= (CW+1)'(m3_cp) - (CW+1)'(arc >>> 16);
      ni     <= (CW+1)'(m3_sp) - (CW+1)'(ars >>> 16);
      m4_den <= m3_den;

      pr     <= m4_side.g * nr;
      pim    <= m4_side.g * ni;
      m5_den <= m4_den;

      // divide magnitudes, sign goes back at the end
      mag_re <= pr[MW-1] ? MW'(-pr) : MW'(pr);
      mag_im <= pim[MW-1] ? MW'(-pim) : MW'(pim);
      m6_den <= m5_den;
    end
  end

  // ---------------------------------------------------------------------------
  // Long division, one quotient bit per stage.
  // ---------------------------------------------------------------------------
  logic [QW-1:0] q_re, q_im;
  logic          ovf_re, ovf_im;
  side_t         dv_side;

  ssfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .mag_re   (mag_re),
    .mag_im   (mag_im),
    .den      (m6_den),
    .side_in  (m6_side),
    .q_re     (q_re),
    .q_im     (q_im),
    .ovf_re   (ovf_re),
    .ovf_im   (ovf_im),
    .side_out (dv_side)
  );

  // truncated quotient back to signed, saturate to 32 bits
  function automatic logic [31:0] sat_q(input logic [QW-1:0] q, input logic ovf,
                                        input logic neg);
    logic [QW-1:0] nq;
    nq = -q;
    if (!neg) begin
      sat_q = (ovf || q[QW-1] || q[31]) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      sat_q = (ovf || q > {2'b01, 31'b0}) ? 32'h8000_0000 : nq[31:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output register: holds while the far side stalls.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_index <= dv_side.idx;
      last         <= dv_side.last;
      out_of_range <= dv_side.bad;
      real_part    <= dv_side.bad ? '0 : sat_q(q_re, ovf_re, dv_side.neg_re);
      imag_part    <= dv_side.bad ? '0 : sat_q(q_im, ovf_im, dv_side.neg_im);
    end
  end

endmodule

### dv/tb_ssfp_ellipse_signal.sv
module tb_ssfp_ellipse_signal;
  import ssfp_pkg::*;

  localparam int NPH       = MAX_PHASES_DEF;
  localparam int ABITS     = ANGLE_BITS_DEF;
  localparam int DRAIN_CYC = 120;     // beyond the pipeline depth
  localparam int HOLD_CYC  = 400;     // long receiver hold-off
  localparam int CYC_LIMIT = 400000;

  typedef struct {
    logic signed [31:0]      gain;
    logic [15:0]             a;
    logic [15:0]             b;
    logic signed [ABITS-1:0] theta0;
    logic signed [ABITS-1:0] psi0;
  } param_set_t;

  typedef struct {
    logic [2:0]         idx;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               oor;
    logic               lst;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [31:0]      gain = '0;
  logic [15:0]             coef_a = '0;
  logic [15:0]             coef_b = '0;
  logic signed [ABITS-1:0] off_res_angle = '0;
  logic signed [ABITS-1:0] rf_phase = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [2:0]              sample_index;
  logic signed [31:0]      real_part;
  logic signed [31:0]      imag_part;
  logic                    out_of_range;
  logic                    last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [2:0]              cfg_index = '0;
  logic [ABITS-1:0]        cfg_data = '0;

  ssfp_ellipse_signal dut (.*);

  // shadow register file, updated on each configuration transfer
  logic [2:0]       sh_count;
  logic [ABITS-1:0] sh_inc [NPH];

  param_set_t pending_sets[$];
  sample_t    expected_samples[$];
  param_set_t drv_set;

  int  send_idle = 0;      // percent of cycles the sender idles
  int  recv_idle = 0;      // percent of cycles the receiver stalls
  bit  hold_arm  = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  n_errors  = 0;
  int  n_sets    = 0;
  int  n_samples = 0;
  int  n_bad     = 0;
  int  n_sat     = 0;
  int  cycles    = 0;

  // clock and cycle limit
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still expected",
               cycles, expected_samples.size());
      $display("** ssfp_ellipse_signal: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // predictor: fixed-point bSSFP ellipse signal
  // ---------------------------------------------------------------------
  function automatic logic [31:0] ang_turn(input logic [ABITS-1:0] v);
    return {v, {(32 - ABITS){1'b0}}};
  endfunction

  // rotate the gain vector into sine and cosine, Q2.30
  function automatic void sincos(input logic [31:0] ang, output longint c, output longint s);
    logic   flip;
    longint x, y, z, dx, dy;
    flip = ((ang + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) ang = ang + 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TURN[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TURN[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // work out every sample that one parameter set yields
  task automatic predict_samples(input param_set_t p);
    longint unsigned ua, ub;
    logic [31:0] t0, p0, half, th;
    longint g, cp, sp, ct, st, rc, rs, nr, ni, den, re, im;
    int cnt;
    bit bad;
    sample_t smp;
    g   = longint'(p.gain);
    ua  = p.a;
    ub  = p.b;
    cnt = (sh_count > NPH) ? NPH : sh_count;
    bad = ub * ((64'd1 << 32) + ua * ua) > ((64'd2 * ua) << 32);
    t0  = ang_turn(p.theta0);
    p0  = ang_turn(p.psi0);
    half = (t0 >> 1) | (t0 & 32'h8000_0000);
    half = half & ~((32'd1 << (32 - ABITS)) - 1);
    sincos(half + p0, cp, sp);
    n_sets++;
    if (bad) n_bad++;
    for (int k = 0; k < cnt; k++) begin
      re = 0;
      im = 0;
      if (!bad) begin
        th = t0 - ang_turn(sh_inc[k]);
        sincos(th, ct, st);
        rc  = (ct * cp - st * sp) >>> 30;
        rs  = (ct * sp + st * cp) >>> 30;
        nr  = cp - ((longint'(ua) * rc) >>> 16);
        ni  = sp - ((longint'(ua) * rs) >>> 16);
        den = 64'sd1073741824 - ((longint'(ub) * ct) >>> 16);
        if (den < 1) den = 1;       // clamp a vanishing denominator
        re = (g * nr) / den;
        im = (g * ni) / den;
      end
      smp.idx = k[2:0];
      smp.re  = clip32(re);
      smp.im  = clip32(im);
      smp.oor = bad;
      smp.lst = (k + 1 == cnt);
      if (smp.re != re || smp.im != im) n_sat++;
      expected_samples.push_back(smp);
    end
  endtask

  // ---------------------------------------------------------------------
  // driver: offer parameter sets from the pending queue
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // a transfer completes here: predict from the set on the wires
      if (in_valid && !in_stall) predict_samples(drv_set);
      // hold the payload while stalled, otherwise advance
      if (!in_valid || !in_stall) begin
        if (pending_sets.size() > 0 && $urandom_range(99) >= send_idle) begin
          drv_set = pending_sets.pop_front();
          gain          <= drv_set.gain;
          coef_a        <= drv_set.a;
          coef_b        <= drv_set.b;
          off_res_angle <= drv_set.theta0;
          rf_phase      <= drv_set.psi0;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: check each sample transfer against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_samples++;
        if (expected_samples.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected sample idx %0d re %0d im %0d", $time,
                   sample_index, real_part, imag_part);
        end else begin
          want = expected_samples.pop_front();
          if (sample_index !== want.idx || real_part !== want.re ||
              imag_part !== want.im || out_of_range !== want.oor || last !== want.lst) begin
            n_errors++;
            $display("%0t: sample mismatch expected idx %0d re %0d im %0d oor %0b last %0b",
                     $time, want.idx, want.re, want.im, want.oor, want.lst);
            $display("%0t:                 actual   idx %0d re %0d im %0d oor %0b last %0b",
                     $time, sample_index, real_part, imag_part, out_of_range, last);
          end
        end
      end
      // long hold-off once, so the pipeline fills and stalls its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_arm && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYC;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [ABITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_COUNT) sh_count = val[2:0];
    else if (idx <= REG_INC_LAST) sh_inc[idx - 3'd1] = val;
  endtask

  // wait for every sample, then let the pipeline settle
  task automatic drain();
    while (pending_sets.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic add_set(input logic signed [31:0] g, input logic [15:0] a,
                         input logic [15:0] b, input logic signed [ABITS-1:0] t,
                         input logic signed [ABITS-1:0] p);
    param_set_t s;
    s.gain = g; s.a = a; s.b = b; s.theta0 = t; s.psi0 = p;
    pending_sets.push_back(s);
  endtask

  // mostly sets inside the ellipse bound, some anywhere
  task automatic add_random_sets(input int n);
    logic signed [31:0] g;
    logic [15:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = 16'($urandom);
      b = ($urandom_range(99) < 70) ? 16'($urandom_range(0, a)) : 16'($urandom);
      case ($urandom_range(3))
        0:       g = $urandom;
        1:       g = $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
        default: g = $signed(32'($urandom_range(0, 1 << 17))) - (1 << 16);
      endcase
      add_set(g, a, b, ABITS'($urandom), ABITS'($urandom));
    end
  endtask

  initial begin
    sh_count = 3'd4;
    sh_inc   = '{16'd0, 16'd16384, 16'h8000, 16'hC000, 16'd0, 16'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, extremes of every field and the special cases
    send_idle = 33; recv_idle = 63;
    add_set(32'sh0001_0000, 16'd0, 16'd0, 16'sd0, 16'sd0);
    add_set(32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0);      // tiny denominator
    add_set(32'sh8000_0000, 16'hFFFF, 16'hFFFF, 16'sd16384, 16'sd0);
    add_set(32'sh7FFF_FFFF, 16'h8000, 16'hC000, 16'sh8000, 16'sh7FFF);
    add_set(32'sh8000_0000, 16'h0000, 16'hFFFF, 16'sh7FFF, 16'sh8000); // out of range
    add_set(32'sh0000_0000, 16'h1234, 16'h0001, -16'sd1, 16'sd1);
    add_set(-32'sd1, 16'h0001, 16'h0002, 16'sh8000, 16'sh8000);
    add_set(32'sh0001_0000, 16'h0001, 16'h0003, 16'sd1, -16'sd1);     // just past the bound
    add_set(32'sh0100_0000, 16'hAAAA, 16'h5555, 16'sh5555, 16'shAAAA);
    add_set(32'sh5555_5555, 16'h5555, 16'hAAAA, 16'shAAAA, 16'sh5555);
    add_set(32'shAAAA_AAAA, 16'hFFFE, 16'hFFFF, 16'sh4000, 16'shC000);
    add_set(32'sh0002_0000, 16'h8000, 16'h0000, 16'shC000, 16'sh4000);
    drain();

    // increments at their extremes and one arbitrary value, full count; index 7 must be ignored
    write_reg(REG_COUNT, 16'd6);
    write_reg(3'd1, 16'h8000);
    write_reg(3'd2, 16'h7FFF);
    write_reg(3'd3, 16'h0000);
    write_reg(3'd4, 16'h0001);
    write_reg(3'd5, 16'hFFFF);
    write_reg(REG_INC_LAST, 16'h3039);
    write_reg(3'd7, 16'h0002);
    add_set(32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'sd0);
    add_set(32'sh0001_0000, 16'h4000, 16'h2000, 16'sh7FFF, 16'sd0);
    add_random_sets(140);
    drain();

    // zero count: sets are taken but yield nothing
    write_reg(REG_COUNT, 16'd0);
    add_random_sets(6);
    drain();

    // count above the limit, roles of the two sides swapped, long hold-off
    send_idle = 63; recv_idle = 33;
    write_reg(REG_COUNT, 16'd7);
    for (int k = 1; k <= 6; k++) write_reg(k[2:0], 16'($urandom));
    send_idle = 0;
    add_random_sets(40);
    hold_arm = 1'b1;
    while (pending_sets.size() > 20) @(posedge clk);
    send_idle = 63;
    add_random_sets(110);
    drain();

    // no idling, single sample per set
    send_idle = 0; recv_idle = 0;
    write_reg(REG_COUNT, 16'd1);
    write_reg(3'd1, 16'($urandom));
    add_random_sets(100);
    drain();

    write_reg(REG_COUNT, 16'd3);
    for (int k = 1; k <= 3; k++) write_reg(k[2:0], 16'($urandom));
    add_random_sets(50);
    drain();

    $display("covered %0d parameter sets and %0d samples over counts 0 to 7",
             n_sets, n_samples);
    $display("  %0d sets out of range, %0d saturated samples, %0d mismatches",
             n_bad, n_sat, n_errors);
    if (n_errors == 0 && expected_samples.size() == 0) begin
      $display("** ssfp_ellipse_signal: PASSED **");
    end else begin
      $display("** ssfp_ellipse_signal: FAILED **");
    end
    $finish;
  end

endmodule
